FILE: design/tdph_pkg.sv
package tdph_pkg;

	// operation codes carried in the mode field
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_UPDATE,
		S_CLEAR
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic rd_en;
		logic upd_en;
		logic sweep_en;
	} ctl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic out_free;
	} dp_status_t;

	// reset value of the cluster count register
	localparam logic [10:0] CLUSTER_COUNT_RESET = 11'd1024;

endpackage

FILE: design/two_way_depth_preferred_hash_table_top.sv
// result: an accepted insert or lookup passes the read state, then the update state once the output register is free
// issue: in_stall stays high until the current insert or lookup has done its update
// clear: sweeps CLUSTERS rows one per cycle, then the result passes the update state
// reset: asynchronous, active low; counters zero, cluster_count 1024
// after reset the table is swept through all CLUSTERS rows with in_stall high
// config writes are taken at any time, ready is always high
module two_way_depth_preferred_hash_table_top #(
	parameter int CLUSTERS   = 1024,
	parameter int KEY_BITS   = 64,
	parameter int LEVEL_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] hash,
	input  logic [63:0] state_key,
	input  logic [7:0]  search_depth,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic        stored,
	output logic        evicted,
	output logic [11:0] occupied_total,
	output logic [31:0] evictions_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	import tdph_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	tdph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.cmd      (cmd),
		.status   (status)
	);

	// table memory, index and counters
	tdph_datapath #(
		.CLUSTERS   (CLUSTERS),
		.KEY_BITS   (KEY_BITS),
		.LEVEL_BITS (LEVEL_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.mode            (mode),
		.hash            (hash),
		.state_key       (state_key),
		.search_depth    (search_depth),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hit             (hit),
		.stored          (stored),
		.evicted         (evicted),
		.occupied_total  (occupied_total),
		.evictions_total (evictions_total)
	);

endmodule

FILE: design/tdph_ctrl.sv
module tdph_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             mode,
	output tdph_pkg::ctl_cmd_t     cmd,
	input  tdph_pkg::dp_status_t   status
);
	import tdph_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			S_INIT: begin
				cmd.sweep_en = 1'b1;
				if (status.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = (mode == MODE_CLEAR) ? S_CLEAR : S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_UPDATE;
			end
			S_UPDATE: begin
				if (status.out_free) begin
					cmd.upd_en = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.sweep_en = 1'b1;
				if (status.sweep_last) begin
					state_nxt = S_UPDATE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	// a blocked result keeps the update pending
	a_update_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE && !status.out_free) |=> (state_q == S_UPDATE))
		else $error("update left while output register busy");

	// the last sweep row ends the sweep
	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_en && status.sweep_last) |=> !cmd.sweep_en)
		else $error("sweep continued past last row");
`endif

endmodule

FILE: design/tdph_datapath.sv
module tdph_datapath #(
	parameter int CLUSTERS   = 1024,
	parameter int KEY_BITS   = 64,
	parameter int LEVEL_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tdph_pkg::ctl_cmd_t     cmd,
	output tdph_pkg::dp_status_t   status,
	input  logic                   cfg_valid,
	input  logic [10:0]            cfg_data,
	input  logic [1:0]             mode,
	input  logic [63:0]            hash,
	input  logic [63:0]            state_key,
	input  logic [7:0]             search_depth,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output logic                   stored,
	output logic                   evicted,
	output logic [11:0]            occupied_total,
	output logic [31:0]            evictions_total
);
	import tdph_pkg::*;

	localparam int IDX_W = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
	localparam logic [16:0] CL_LIM = 17'(CLUSTERS);
	localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(CLUSTERS - 1);

	typedef struct packed {
		logic                  v0;
		logic                  v1;
		logic [KEY_BITS-1:0]   k0;
		logic [KEY_BITS-1:0]   k1;
		logic [LEVEL_BITS-1:0] l0;
		logic [LEVEL_BITS-1:0] l1;
	} row_t;

	row_t mem [CLUSTERS];

	logic [10:0]           cc_q;
	logic [1:0]            mode_q;
	logic [63:0]           hash_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [LEVEL_BITS-1:0] lvl_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      sweep_q;
	row_t                  row_q;
	logic [11:0]           occ_q;
	logic [31:0]           tally_q;
	logic                  out_valid_q;
	logic                  hit_q;
	logic                  stored_q;
	logic                  evicted_q;

	logic [10:0]     c_eff;
	logic [74:0]     prod;
	logic [16:0]     idx_wide;
	logic [IDX_W-1:0] rd_idx;
	logic [15:0]     lvl_wide;

	logic            is_access;
	logic            h_any;
	logic            ins_new;
	logic            evict_now;
	logic            occ_inc;
	row_t            new_row;
	logic            mem_we;
	logic [IDX_W-1:0] mem_waddr;
	row_t            mem_wdata;

	// cluster count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CLUSTER_COUNT_RESET;
		end else if (cfg_valid) begin
			cc_q <= cfg_data;
		end
	end

	// input capture on accepted transaction
	assign lvl_wide = {8'b0, search_depth};
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= mode;
			hash_q <= hash;
			key_q  <= state_key[KEY_BITS-1:0];
			lvl_q  <= lvl_wide[LEVEL_BITS-1:0];
		end
	end

	// cluster index: high bits of hash times clamped count
	assign c_eff    = ({6'b0, cc_q} > CL_LIM) ? CL_LIM[10:0] : cc_q;
	assign prod     = {11'b0, hash_q} * {64'b0, c_eff};
	assign idx_wide = {6'b0, prod[74:64]};
	assign rd_idx   = idx_wide[IDX_W-1:0];

	// clear sweep row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_en) begin
			sweep_q <= (sweep_q == LAST_ROW) ? '0 : sweep_q + IDX_W'(1);
		end
	end

	// probe and replacement decision
	always_comb begin
		is_access = (mode_q == MODE_INSERT) || (mode_q == MODE_LOOKUP);
		h_any     = is_access && ((row_q.v0 && row_q.k0 == key_q) ||
		                          (row_q.v1 && row_q.k1 == key_q));
		ins_new   = (mode_q == MODE_INSERT) && !h_any;
		evict_now = ins_new && row_q.v0 && row_q.v1;
		occ_inc   = ins_new && !(row_q.v0 && row_q.v1);
		new_row   = row_q;
		if (!row_q.v0) begin
			new_row.v0 = 1'b1;
			new_row.k0 = key_q;
			new_row.l0 = lvl_q;
		end else begin
			new_row.v1 = 1'b1;
			if (lvl_q <= row_q.l0) begin
				new_row.k1 = row_q.k0;
				new_row.l1 = row_q.l0;
				new_row.k0 = key_q;
				new_row.l0 = lvl_q;
			end else begin
				new_row.k1 = key_q;
				new_row.l1 = lvl_q;
			end
		end
	end

	// single write port shared by sweep and update
	assign mem_we    = cmd.sweep_en || (cmd.upd_en && ins_new);
	assign mem_waddr = cmd.sweep_en ? sweep_q : idx_q;
	assign mem_wdata = cmd.sweep_en ? row_t'('0) : new_row;

	// cluster memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en) begin
			row_q <= mem[rd_idx];
			idx_q <= rd_idx;
		end
	end

	// occupancy and eviction counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			tally_q <= '0;
		end else if (cmd.upd_en) begin
			if (mode_q == MODE_CLEAR) begin
				occ_q   <= '0;
				tally_q <= '0;
			end else begin
				if (occ_inc) begin
					occ_q <= occ_q + 12'd1;
				end
				if (evict_now && tally_q != '1) begin
					tally_q <= tally_q + 32'd1;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register flags
	always_ff @(posedge clk) begin
		if (cmd.upd_en) begin
			hit_q     <= h_any;
			stored_q  <= ins_new;
			evicted_q <= evict_now;
		end
	end

	assign status.out_free   = !out_valid_q || !out_stall;
	assign status.sweep_last = (sweep_q == LAST_ROW);

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign stored          = stored_q;
	assign evicted         = evicted_q;
	assign occupied_total  = occ_q;
	assign evictions_total = tally_q;

`ifndef SYNTH
	// memory port used by one step at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.rd_en, cmd.upd_en, cmd.sweep_en}))
		else $error("conflicting datapath commands");

	// a new entry is never reported together with a hit
	a_hit_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && stored_q))
		else $error("hit and stored both set");

	// eviction only happens on a store
	a_evict_store: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && evicted_q) |-> stored_q)
		else $error("eviction without store");
`endif

endmodule
